// ===== sv/c3f_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// c3f_pkg: shared types and constants of the 3x3 clamp filter
// Register indexes, reset values, the classified beat that travels from the
// front end to the back end, and the queue status.
// ----------------------------------------------------------------------------
package c3f_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH     = 3'd0,
    CFG_IMAGE_HEIGHT    = 3'd1,
    CFG_ROI_COLUMNS     = 3'd2,
    CFG_ROI_ROWS        = 3'd3,
    CFG_KERNEL_TAPS_LOW = 3'd4,
    CFG_KERNEL_TAPS_MID = 3'd5,
    CFG_KERNEL_TAP_LAST = 3'd6
  } c3f_cfg_idx_t;

  // Register reset values.
  localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd256;
  localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd256;
  localparam logic [21:0] RST_ROI_COLUMNS  = 22'd524288;
  localparam logic [21:0] RST_ROI_ROWS     = 22'd524288;
  localparam logic [63:0] RST_TAPS_LOW     = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] RST_TAPS_MID     = 64'hFFFF_FFFF_FFFF_0009;
  localparam logic [15:0] RST_TAP_LAST     = 16'hFFFF;

  // Image geometry as held in the configuration registers.
  typedef struct packed {
    logic [10:0] image_width;
    logic [10:0] image_height;
    logic [21:0] roi_columns;
    logic [21:0] roi_rows;
  } c3f_geom_t;

  // Nine 16-bit taps, tap 0 (top left) in element 0.
  typedef logic [8:0][15:0] c3f_taps_t;

  // One classified pixel beat between front end and back end.
  typedef struct packed {
    logic [7:0] pixel;
    logic       emit;
    logic [9:0] col;
    logic [9:0] row;
    logic       last;
  } c3f_item_t;

  // Queue status seen by both ends.
  typedef struct packed {
    logic full;
    logic nonempty;
  } c3f_q_stat_t;

  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 4;

endpackage
`default_nettype wire

// ===== sv/c3f_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// c3f channel interfaces
// Pixel input, filtered result and configuration write channels, each a
// valid/ready pair with its payload.
// ----------------------------------------------------------------------------
interface c3f_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_in;
  logic       frame_start;

  modport source (output valid, output pixel_in, output frame_start, input ready);
  modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

interface c3f_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] filtered_pixel;
  logic [9:0] out_column;
  logic [9:0] out_row;
  logic       last_of_frame;

  modport source (output valid, output filtered_pixel, output out_column,
                  output out_row, output last_of_frame, input ready);
  modport sink   (input valid, input filtered_pixel, input out_column,
                  input out_row, input last_of_frame, output ready);
endinterface

interface c3f_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [c3f_pkg::CFG_IDX_W-1:0]   index;
  logic [63:0]                     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/c3f_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// c3f_front: position tracking and region classification
// Accepts pixel beats, keeps the column and row counters, and tags every
// pixel with its line store address and whether its window centre emits.
// ----------------------------------------------------------------------------
module c3f_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  wire                 clk,
  input  wire                 rst_n,
  c3f_in_if.sink              in_bus,
  input  c3f_pkg::c3f_geom_t  geom,
  input  c3f_pkg::c3f_q_stat_t q_stat,
  output logic                push,
  output c3f_pkg::c3f_item_t  item,
  output logic [CW-1:0]       addr
);

  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WB  = $clog2(MAX_WIDTH + 1);
  localparam int HB  = $clog2(MAX_HEIGHT + 1);
  localparam int VW0 = (WB > HB) ? WB : HB;
  localparam int VW  = (VW0 > 11) ? VW0 : 11;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [VW-1:0] wx, hx, w, h, cs, ce, rs, re;
  logic [VW-1:0] c, r, cc, cr, c_inc, r_inc;
  logic          emit;

  // Effective image size and region bounds.
  always_comb begin
    wx = VW'(geom.image_width);
    hx = VW'(geom.image_height);
    w  = (wx < VW'(3)) ? VW'(3) : ((wx > VW'(MAX_WIDTH)) ? VW'(MAX_WIDTH) : wx);
    h  = (hx < VW'(3)) ? VW'(3) : ((hx > VW'(MAX_HEIGHT)) ? VW'(MAX_HEIGHT) : hx);
    cs = VW'(geom.roi_columns[10:0]);
    ce = VW'(geom.roi_columns[21:11]);
    rs = VW'(geom.roi_rows[10:0]);
    re = VW'(geom.roi_rows[21:11]);
    if (cs == '0) begin
      cs = VW'(1);
    end
    if (rs == '0) begin
      rs = VW'(1);
    end
    if (ce >= w) begin
      ce = w - VW'(1);
    end
    if (re >= h) begin
      re = h - VW'(1);
    end
  end

  // Position of this pixel, its window centre and the next position.
  always_comb begin
    c = (in_bus.frame_start || (VW'(col_r) >= w)) ? '0 : VW'(col_r);
    r = (in_bus.frame_start || (VW'(row_r) >= h)) ? '0 : VW'(row_r);
    cc = c - VW'(1);
    cr = r - VW'(1);
    emit = (c != '0) && (r != '0) && (cc >= cs) && (cc < ce) &&
           (cr >= rs) && (cr < re);
    c_inc = c + VW'(1);
    r_inc = r + VW'(1);
    if (c_inc >= w) begin
      col_nxt = '0;
      row_nxt = (r_inc >= h) ? '0 : r_inc[RW-1:0];
    end else begin
      col_nxt = c_inc[CW-1:0];
      row_nxt = r[RW-1:0];
    end
  end

  // Beat toward the queue.
  assign in_bus.ready = !q_stat.full;
  assign push         = in_bus.valid && in_bus.ready;
  assign addr         = c[CW-1:0];

  always_comb begin
    item.pixel = in_bus.pixel_in;
    item.emit  = emit;
    item.col   = cc[9:0];
    item.row   = cr[9:0];
    item.last  = (cc == ce - VW'(1)) && (cr == re - VW'(1));
  end

  // Position counters advance on every accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (push) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/c3f_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// c3f_queue: short queue between front end and back end
// Holds classified pixel beats with their line store address so that either
// side can stall without holding up the other.
// ----------------------------------------------------------------------------
module c3f_queue #(
  parameter int AW = 10
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  c3f_pkg::c3f_item_t    push_item,
  input  wire [AW-1:0]          push_addr,
  input  wire                   pop,
  output c3f_pkg::c3f_item_t    head_item,
  output logic [AW-1:0]         head_addr,
  output c3f_pkg::c3f_q_stat_t  stat
);

  localparam int QA = c3f_pkg::QUEUE_AW;
  localparam int QD = c3f_pkg::QUEUE_DEPTH;

  c3f_pkg::c3f_item_t item_q [QD];
  logic [AW-1:0]      addr_q [QD];
  logic [QA-1:0]      wr_ptr_r, rd_ptr_r;
  logic [QA:0]        count_r, count_nxt;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      item_q[wr_ptr_r] <= push_item;
      addr_q[wr_ptr_r] <= push_addr;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QA+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QA+1)'(1);
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QA'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QA'(1);
      end
      count_r <= count_nxt;
    end
  end

  assign head_item     = item_q[rd_ptr_r];
  assign head_addr     = addr_q[rd_ptr_r];
  assign stat.full     = (count_r == (QA+1)'(QD));
  assign stat.nonempty = (count_r != '0);

endmodule
`default_nettype wire

// ===== sv/c3f_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// c3f_back: line stores, window and multiply-accumulate pipeline
// Reads and rewrites the two line stores, shifts the 3x3 window, forms the
// nine tap products, sums them with 16-bit wrap and clamps to 0..255.
// ----------------------------------------------------------------------------
module c3f_back #(
  parameter int MAX_WIDTH = 1024,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  c3f_pkg::c3f_q_stat_t q_stat,
  input  c3f_pkg::c3f_item_t   head_item,
  input  wire [CW-1:0]         head_addr,
  input  c3f_pkg::c3f_taps_t   taps,
  output logic                 pop,
  c3f_out_if.source            out_bus
);

  localparam logic [7:0] PIX_MAX = 8'd255;

  logic [7:0] upper_mem  [MAX_WIDTH];
  logic [7:0] middle_mem [MAX_WIDTH];

  logic adv;

  // Stage 1: line store read.
  logic               s1_v_r;
  c3f_pkg::c3f_item_t s1_item_r;
  logic [CW-1:0]      s1_addr_r;
  logic [7:0]         up_raw_r, mid_raw_r;
  logic               byp_r;
  logic [7:0]         byp_up_r, byp_mid_r;
  logic [7:0]         up1, mid1;
  logic               byp_nxt;

  // Stage 2: window.
  logic               s2_v_r;
  c3f_pkg::c3f_item_t s2_item_r;
  logic [8:0][7:0]    win_r, win_nxt;

  // Stage 3: products.
  logic               s3_v_r;
  c3f_pkg::c3f_item_t s3_item_r;
  logic [8:0][15:0]   prod_r, prod_nxt;
  logic [8:0][23:0]   prod_full;

  // Stage 4: partial sums.
  logic               s4_v_r;
  c3f_pkg::c3f_item_t s4_item_r;
  logic [2:0][15:0]   psum_r, psum_nxt;

  // Output register.
  logic       out_vld_r;
  logic [7:0] pix_r, pix_nxt;
  logic [9:0] col_r;
  logic [9:0] row_r;
  logic       last_r;
  logic [15:0] acc;

  // The whole pipeline moves when the output register can take a beat.
  assign adv = !out_vld_r || out_bus.ready;
  assign pop = adv && q_stat.nonempty;

  // Same address written by the beat leaving stage 1 as read now: forward.
  assign byp_nxt = s1_v_r && (s1_addr_r == head_addr);
  assign up1     = byp_r ? byp_up_r : up_raw_r;
  assign mid1    = byp_r ? byp_mid_r : mid_raw_r;

  // Line stores: read for the new beat, rewrite for the beat in stage 1.
  always_ff @(posedge clk) begin
    if (adv && s1_v_r) begin
      upper_mem[s1_addr_r]  <= mid1;
      middle_mem[s1_addr_r] <= s1_item_r.pixel;
    end
    if (pop) begin
      up_raw_r  <= upper_mem[head_addr];
      mid_raw_r <= middle_mem[head_addr];
    end
  end

  // Window shift with the new column on the right.
  always_comb begin
    win_nxt    = win_r;
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = up1;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = mid1;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = s1_item_r.pixel;
  end

  // Tap products; only the low 16 bits count under wrapping adds.
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      prod_full[k] = taps[k] * win_r[k];
      prod_nxt[k]  = prod_full[k][15:0];
    end
    for (int g = 0; g < 3; g++) begin
      psum_nxt[g] = prod_r[3*g] + prod_r[3*g+1] + prod_r[3*g+2];
    end
  end

  // Final sum and clamp to the pixel range.
  always_comb begin
    acc = psum_r[0] + psum_r[1] + psum_r[2];
    if (acc[15]) begin
      pix_nxt = '0;
    end else if (acc > 16'(PIX_MAX)) begin
      pix_nxt = PIX_MAX;
    end else begin
      pix_nxt = acc[7:0];
    end
  end

  // Pipeline control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      s4_v_r    <= 1'b0;
      out_vld_r <= 1'b0;
      byp_r     <= 1'b0;
      win_r     <= '0;
    end else if (adv) begin
      s1_v_r    <= pop;
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r;
      s4_v_r    <= s3_v_r;
      out_vld_r <= s4_v_r && s4_item_r.emit;
      byp_r     <= pop && byp_nxt;
      if (s1_v_r) begin
        win_r <= win_nxt;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r <= head_item;
      s1_addr_r <= head_addr;
      byp_up_r  <= mid1;
      byp_mid_r <= s1_item_r.pixel;
      s2_item_r <= s1_item_r;
      s3_item_r <= s2_item_r;
      prod_r    <= prod_nxt;
      s4_item_r <= s3_item_r;
      psum_r    <= psum_nxt;
      pix_r     <= pix_nxt;
      col_r     <= s4_item_r.col;
      row_r     <= s4_item_r.row;
      last_r    <= s4_item_r.last;
    end
  end

  assign out_bus.valid          = out_vld_r;
  assign out_bus.filtered_pixel = pix_r;
  assign out_bus.out_column     = col_r;
  assign out_bus.out_row        = row_r;
  assign out_bus.last_of_frame  = last_r;

endmodule
`default_nettype wire

// ===== sv/conv3x3_clamp_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// conv3x3_clamp_filter: streaming 3x3 convolution with clamp to 0..255
// Top level: configuration registers, front end, queue and back end.
// ----------------------------------------------------------------------------
// The filter takes one grey pixel per clock in raster order and gives one
// result per clock for every pixel whose 3x3 neighborhood centre lies in the
// region of interest while nothing stalls, a sustained rate set by the single
// read and single write port of each line store, both used once per beat;
// border pixels never produce a result. A pixel beat passes the queue, line
// store read, window, product, partial sum and output registers in order.
// The two line stores are MAX_WIDTH x 8 memories with no reset and no
// clearing pass, so a frame should begin with its first row; reading a column
// never written since reset or since the width grew gives an undefined pixel.
// A four-entry queue between the front end and the back end absorbs short
// stalls of the result channel. Configuration is taken at any time but must
// only change while the filter is idle.
module conv3x3_clamp_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire        clk,
  input  wire        rst_n,
  c3f_in_if.sink     in_bus,
  c3f_out_if.source  out_bus,
  c3f_cfg_if.sink    cfg_bus
);

  localparam int CW = $clog2(MAX_WIDTH);

  c3f_pkg::c3f_geom_t   geom_r;
  c3f_pkg::c3f_taps_t   taps_r;
  c3f_pkg::c3f_q_stat_t q_stat;
  c3f_pkg::c3f_item_t   fe_item, q_item;
  logic [CW-1:0]        fe_addr, q_addr;
  logic                 fe_push, q_pop;

  // Configuration registers.
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r.image_width  <= c3f_pkg::RST_IMAGE_WIDTH;
      geom_r.image_height <= c3f_pkg::RST_IMAGE_HEIGHT;
      geom_r.roi_columns  <= c3f_pkg::RST_ROI_COLUMNS;
      geom_r.roi_rows     <= c3f_pkg::RST_ROI_ROWS;
      taps_r[3:0]         <= c3f_pkg::RST_TAPS_LOW;
      taps_r[7:4]         <= c3f_pkg::RST_TAPS_MID;
      taps_r[8]           <= c3f_pkg::RST_TAP_LAST;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        c3f_pkg::CFG_IMAGE_WIDTH:     geom_r.image_width  <= cfg_bus.data[10:0];
        c3f_pkg::CFG_IMAGE_HEIGHT:    geom_r.image_height <= cfg_bus.data[10:0];
        c3f_pkg::CFG_ROI_COLUMNS:     geom_r.roi_columns  <= cfg_bus.data[21:0];
        c3f_pkg::CFG_ROI_ROWS:        geom_r.roi_rows     <= cfg_bus.data[21:0];
        c3f_pkg::CFG_KERNEL_TAPS_LOW: taps_r[3:0]         <= cfg_bus.data;
        c3f_pkg::CFG_KERNEL_TAPS_MID: taps_r[7:4]         <= cfg_bus.data;
        c3f_pkg::CFG_KERNEL_TAP_LAST: taps_r[8]           <= cfg_bus.data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: counters and classification.
  c3f_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .geom   (geom_r),
    .q_stat (q_stat),
    .push   (fe_push),
    .item   (fe_item),
    .addr   (fe_addr)
  );

  // Queue between the two ends.
  c3f_queue #(
    .AW (CW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fe_push),
    .push_item (fe_item),
    .push_addr (fe_addr),
    .pop       (q_pop),
    .head_item (q_item),
    .head_addr (q_addr),
    .stat      (q_stat)
  );

  // Back end: line stores, window and arithmetic.
  c3f_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_item (q_item),
    .head_addr (q_addr),
    .taps      (taps_r),
    .pop       (q_pop),
    .out_bus   (out_bus)
  );

  // A frame start beat always lands in the first column of the line stores.
  a_frame_start_col0: assert property (@(posedge clk) disable iff (!rst_n)
    (fe_push && in_bus.frame_start) |-> (fe_addr == '0))
    else $error("frame start beat not placed at column zero");

  // A beat that emits never sits in the first column or the first row.
  a_emit_not_border: assert property (@(posedge clk) disable iff (!rst_n)
    (fe_push && fe_item.emit) |-> ((fe_addr != '0) && !in_bus.frame_start))
    else $error("border pixel classified as emitting");

  // The back end only pops a queue that holds a beat.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_stat.nonempty)
    else $error("queue popped while empty");

  // A full queue takes no new beat.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !fe_push)
    else $error("queue pushed while full");

endmodule
`default_nettype wire
